>>> src/evseq_pkg.sv
// ----------------------------------------------------------------------------
// EV DC charge session sequencer package
// Phase and event codes, request and result payload types.
// ----------------------------------------------------------------------------
package evseq_pkg;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_PLUG_IN    = 4'd1,
        PH_HANDSHAKE  = 4'd2,
        PH_LOCK       = 4'd3,
        PH_INSULATION = 4'd4,
        PH_TRANSFER   = 4'd5,
        PH_WINDDOWN   = 4'd6,
        PH_INHIBITED  = 4'd7,
        PH_ERROR      = 4'd8
    } phase_t;

    localparam logic [3:0] EV_PLUG_IN     = 4'd0;
    localparam logic [3:0] EV_PLUG_OUT    = 4'd1;
    localparam logic [3:0] EV_BMS_UPDATE  = 4'd2;
    localparam logic [3:0] EV_IN1_ON      = 4'd3;
    localparam logic [3:0] EV_IN1_OFF     = 4'd4;
    localparam logic [3:0] EV_IN2_ON      = 4'd5;
    localparam logic [3:0] EV_CAPS        = 4'd6;
    localparam logic [3:0] EV_STATUS      = 4'd7;
    localparam logic [3:0] EV_INHIBIT_ON  = 4'd8;
    localparam logic [3:0] EV_INHIBIT_OFF = 4'd9;

    typedef struct packed {
        logic [3:0] opcode;
        logic       battery_full;
        logic       voltage_sufficient;
        logic       params_complete;
        logic       station_error;
        logic       lock_engaged;
    } req_t;

    typedef struct packed {
        logic start_session;
        logic stop_messages;
        logic shutdown;
        logic go_ahead;
        logic reset_session;
        logic out1_off;
        logic close_contactors;
        logic recalc_current;
        logic recalc_time;
        logic ramp_down;
    } action_t;

    typedef struct packed {
        logic [3:0] phase;
        logic       invalid_event;
        logic       start_session;
        logic       stop_messages;
        logic       shutdown;
        logic       go_ahead;
        logic       reset_session;
        logic       out1_off;
        logic       close_contactors;
        logic       recalc_current;
        logic       recalc_time;
        logic       ramp_down;
    } rsp_t;

endpackage

>>> src/evseq_req_if.sv
// ----------------------------------------------------------------------------
// EV DC charge session sequencer request channel
// Valid/ready channel carrying one event with its condition flags.
// ----------------------------------------------------------------------------
interface evseq_req_if;
    logic              valid;
    logic              ready;
    evseq_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/evseq_rsp_if.sv
// ----------------------------------------------------------------------------
// EV DC charge session sequencer result channel
// Valid/ready channel carrying the new phase and the action pulses.
// ----------------------------------------------------------------------------
interface evseq_rsp_if;
    logic              valid;
    logic              ready;
    evseq_pkg::rsp_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/ev_dc_charge_session_sequencer_unit.sv
// ----------------------------------------------------------------------------
// EV DC charge session sequencer
// Vehicle-side charge phase sequencer: one event request in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event code with the battery manager and station flags.
//   rsp returns the phase after that event, an invalid-event flag and the
//   action pulses it causes; every request gives exactly one result.
//   A request is taken into an input register, decoded against the current
//   phase and written to a result register that drives rsp. One request is
//   accepted every cycle while results are taken; the phase decode between
//   the input register and the result register is combinational.
//   When rsp stalls, the result register holds, the input register fills
//   behind it, and req.ready drops until the result is taken.
//   Reset empties both registers and returns the phase to idle.
// ----------------------------------------------------------------------------
module ev_dc_charge_session_sequencer_unit
(
    input  logic         clk,
    input  logic         rst_n,
    evseq_req_if.sink    req,
    evseq_rsp_if.source  rsp
);

    logic               in_valid_reg;
    evseq_pkg::req_t    in_data_reg;
    logic               out_valid_reg;
    evseq_pkg::rsp_t    out_data_reg;
    evseq_pkg::phase_t  phase_reg;
    evseq_pkg::phase_t  phase_next;
    logic               bad;
    evseq_pkg::action_t act;
    evseq_pkg::rsp_t    rsp_next;
    logic               out_load;

    assign out_load  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || out_load;

    // next phase and invalid-event decode
    always_comb
    begin
        phase_next = phase_reg;
        bad        = 1'b0;
        case (phase_reg)
            evseq_pkg::PH_IDLE:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_PLUG_IN:    phase_next = evseq_pkg::PH_PLUG_IN;
                    evseq_pkg::EV_BMS_UPDATE:
                    begin
                        if (in_data_reg.battery_full)
                        begin
                            phase_next = evseq_pkg::PH_INHIBITED;
                        end
                    end
                    evseq_pkg::EV_INHIBIT_ON: phase_next = evseq_pkg::PH_INHIBITED;
                    default:                  bad = 1'b1;
                endcase
            end
            evseq_pkg::PH_PLUG_IN:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_BMS_UPDATE:
                    begin
                        if (in_data_reg.battery_full)
                        begin
                            phase_next = evseq_pkg::PH_INHIBITED;
                        end
                    end
                    evseq_pkg::EV_IN1_ON:     phase_next = evseq_pkg::PH_HANDSHAKE;
                    evseq_pkg::EV_PLUG_OUT:   phase_next = evseq_pkg::PH_IDLE;
                    evseq_pkg::EV_INHIBIT_ON: phase_next = evseq_pkg::PH_INHIBITED;
                    default:                  bad = 1'b1;
                endcase
            end
            evseq_pkg::PH_HANDSHAKE:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_IN1_OFF:    phase_next = evseq_pkg::PH_PLUG_IN;
                    evseq_pkg::EV_BMS_UPDATE:
                    begin
                        if (in_data_reg.battery_full)
                        begin
                            phase_next = evseq_pkg::PH_INHIBITED;
                        end
                    end
                    evseq_pkg::EV_CAPS:
                    begin
                        if (!in_data_reg.voltage_sufficient)
                        begin
                            phase_next = evseq_pkg::PH_ERROR;
                        end
                        else if (in_data_reg.params_complete)
                        begin
                            phase_next = evseq_pkg::PH_LOCK;
                        end
                    end
                    evseq_pkg::EV_STATUS:
                    begin
                        if (in_data_reg.station_error)
                        begin
                            phase_next = evseq_pkg::PH_ERROR;
                        end
                        else if (in_data_reg.params_complete)
                        begin
                            phase_next = evseq_pkg::PH_LOCK;
                        end
                    end
                    evseq_pkg::EV_PLUG_OUT:   phase_next = evseq_pkg::PH_IDLE;
                    evseq_pkg::EV_INHIBIT_ON: phase_next = evseq_pkg::PH_INHIBITED;
                    default:                  bad = 1'b1;
                endcase
            end
            evseq_pkg::PH_LOCK:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_IN1_OFF:    phase_next = evseq_pkg::PH_PLUG_IN;
                    evseq_pkg::EV_BMS_UPDATE:
                    begin
                        if (in_data_reg.battery_full)
                        begin
                            phase_next = evseq_pkg::PH_INHIBITED;
                        end
                    end
                    evseq_pkg::EV_CAPS:       phase_next = phase_reg;
                    evseq_pkg::EV_STATUS:
                    begin
                        if (in_data_reg.station_error)
                        begin
                            phase_next = evseq_pkg::PH_ERROR;
                        end
                        else if (in_data_reg.lock_engaged)
                        begin
                            phase_next = evseq_pkg::PH_INSULATION;
                        end
                    end
                    evseq_pkg::EV_PLUG_OUT:   phase_next = evseq_pkg::PH_IDLE;
                    evseq_pkg::EV_INHIBIT_ON: phase_next = evseq_pkg::PH_INHIBITED;
                    default:                  bad = 1'b1;
                endcase
            end
            evseq_pkg::PH_INSULATION:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_IN1_OFF:    phase_next = evseq_pkg::PH_PLUG_IN;
                    evseq_pkg::EV_BMS_UPDATE:
                    begin
                        if (in_data_reg.battery_full)
                        begin
                            phase_next = evseq_pkg::PH_INHIBITED;
                        end
                    end
                    evseq_pkg::EV_IN2_ON:     phase_next = evseq_pkg::PH_TRANSFER;
                    evseq_pkg::EV_PLUG_OUT:   phase_next = evseq_pkg::PH_IDLE;
                    evseq_pkg::EV_INHIBIT_ON: phase_next = evseq_pkg::PH_INHIBITED;
                    default:                  bad = 1'b1;
                endcase
            end
            evseq_pkg::PH_TRANSFER:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_BMS_UPDATE:
                    begin
                        if (in_data_reg.battery_full)
                        begin
                            phase_next = evseq_pkg::PH_WINDDOWN;
                        end
                    end
                    evseq_pkg::EV_PLUG_OUT:   phase_next = evseq_pkg::PH_IDLE;
                    evseq_pkg::EV_CAPS:       phase_next = phase_reg;
                    evseq_pkg::EV_STATUS:
                    begin
                        if (in_data_reg.station_error)
                        begin
                            phase_next = evseq_pkg::PH_ERROR;
                        end
                    end
                    evseq_pkg::EV_INHIBIT_ON: phase_next = evseq_pkg::PH_INHIBITED;
                    default:                  bad = 1'b1;
                endcase
            end
            evseq_pkg::PH_WINDDOWN:
            begin
                if (!(in_data_reg.opcode inside {evseq_pkg::EV_BMS_UPDATE, evseq_pkg::EV_CAPS,
                                                 evseq_pkg::EV_STATUS, evseq_pkg::EV_PLUG_OUT,
                                                 evseq_pkg::EV_INHIBIT_ON}))
                begin
                    bad = 1'b1;
                end
            end
            evseq_pkg::PH_INHIBITED:
            begin
                if (!(in_data_reg.opcode inside {evseq_pkg::EV_BMS_UPDATE,
                                                 evseq_pkg::EV_INHIBIT_OFF}))
                begin
                    bad = 1'b1;
                end
            end
            evseq_pkg::PH_ERROR:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_BMS_UPDATE: phase_next = phase_reg;
                    evseq_pkg::EV_PLUG_OUT:   phase_next = evseq_pkg::PH_IDLE;
                    default:                  bad = 1'b1;
                endcase
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
    end

    // action pulses
    always_comb
    begin
        act = '0;
        case (phase_reg)
            evseq_pkg::PH_PLUG_IN:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_IN1_ON:   act.start_session = 1'b1;
                    evseq_pkg::EV_PLUG_OUT: act.reset_session = 1'b1;
                    default:                act = '0;
                endcase
            end
            evseq_pkg::PH_HANDSHAKE:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_IN1_OFF:    act.shutdown = 1'b1;
                    evseq_pkg::EV_BMS_UPDATE: act.shutdown = in_data_reg.battery_full;
                    evseq_pkg::EV_CAPS:
                    begin
                        act.shutdown = !in_data_reg.voltage_sufficient;
                        act.go_ahead = in_data_reg.voltage_sufficient &&
                                       in_data_reg.params_complete;
                    end
                    evseq_pkg::EV_STATUS:
                    begin
                        act.stop_messages = in_data_reg.station_error;
                        act.go_ahead      = !in_data_reg.station_error &&
                                            in_data_reg.params_complete;
                    end
                    evseq_pkg::EV_PLUG_OUT:   act.reset_session = 1'b1;
                    default:                  act = '0;
                endcase
            end
            evseq_pkg::PH_LOCK:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_IN1_OFF:    act.shutdown = 1'b1;
                    evseq_pkg::EV_BMS_UPDATE: act.shutdown = in_data_reg.battery_full;
                    evseq_pkg::EV_STATUS:     act.stop_messages = in_data_reg.station_error;
                    evseq_pkg::EV_PLUG_OUT:
                    begin
                        act.shutdown      = 1'b1;
                        act.reset_session = 1'b1;
                    end
                    evseq_pkg::EV_INHIBIT_ON: act.out1_off = 1'b1;
                    default:                  act = '0;
                endcase
            end
            evseq_pkg::PH_INSULATION:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_IN1_OFF:    act.shutdown = 1'b1;
                    evseq_pkg::EV_BMS_UPDATE: act.shutdown = in_data_reg.battery_full;
                    evseq_pkg::EV_IN2_ON:     act.close_contactors = 1'b1;
                    evseq_pkg::EV_PLUG_OUT:   act.reset_session = 1'b1;
                    default:                  act = '0;
                endcase
            end
            evseq_pkg::PH_TRANSFER:
            begin
                case (in_data_reg.opcode)
                    evseq_pkg::EV_BMS_UPDATE:
                    begin
                        act.shutdown       = in_data_reg.battery_full;
                        act.recalc_current = !in_data_reg.battery_full;
                    end
                    evseq_pkg::EV_PLUG_OUT:   act.reset_session = 1'b1;
                    evseq_pkg::EV_CAPS:
                    begin
                        act.recalc_current = 1'b1;
                        act.recalc_time    = 1'b1;
                    end
                    evseq_pkg::EV_STATUS:     act.stop_messages = in_data_reg.station_error;
                    default:                  act = '0;
                endcase
            end
            evseq_pkg::PH_WINDDOWN:
            begin
                act.ramp_down = in_data_reg.opcode inside {evseq_pkg::EV_BMS_UPDATE,
                                                           evseq_pkg::EV_CAPS,
                                                           evseq_pkg::EV_STATUS};
            end
            evseq_pkg::PH_ERROR:
            begin
                act.reset_session = (in_data_reg.opcode == evseq_pkg::EV_PLUG_OUT);
            end
            default:
            begin
                act = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.phase            = phase_next;
        rsp_next.invalid_event    = bad;
        rsp_next.start_session    = act.start_session;
        rsp_next.stop_messages    = act.stop_messages;
        rsp_next.shutdown         = act.shutdown;
        rsp_next.go_ahead         = act.go_ahead;
        rsp_next.reset_session    = act.reset_session;
        rsp_next.out1_off         = act.out1_off;
        rsp_next.close_contactors = act.close_contactors;
        rsp_next.recalc_current   = act.recalc_current;
        rsp_next.recalc_time      = act.recalc_time;
        rsp_next.ramp_down        = act.ramp_down;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= evseq_pkg::PH_IDLE;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_data_reg <= req.payload;
        end
        if (out_load)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

endmodule
